// ===== src/sem_pkg.sv =====
// sem_pkg: shared widths, codes and controller/datapath handshake types for
// the sojourn ECN marking FIFO. No dependencies.
`timescale 1ns / 1ps

package sem_pkg;

  // Payload field widths
  localparam int NOW_W   = 48;
  localparam int ID_W    = 16;
  localparam int SIZE_W  = 16;
  localparam int ECN_W   = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int QPKT_W  = 11;
  localparam int QBYTE_W = 26;

  // Config register widths
  localparam int MAXP_W     = 11;
  localparam int MAXB_W     = 32;
  localparam int THR_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOJOURN_THR = 2'd3;

  // Config reset values
  localparam logic [MAXP_W-1:0] MAXP_RST = 11'd100;
  localparam logic [MAXB_W-1:0] MAXB_RST = 32'd150000;
  localparam logic [THR_W-1:0]  THR_RST  = 48'd10000;

  // Opcodes (the unused code behaves as a peek)
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // ECN codepoints
  localparam logic [ECN_W-1:0] ECN_ECT_ONE = 2'b01;
  localparam logic [ECN_W-1:0] ECN_CE      = 2'b11;

  // Descriptor word layout: {ipv4, ecn, size, id}
  localparam int DESC_W = ID_W + SIZE_W + ECN_W + 1;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_DEQUEUED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_PEEKED   = 3'd4
  } sem_status_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, read head entry
    logic exec;     // execute latched request, load result register
  } sem_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free; // result register empty or being taken this cycle
  } sem_stat_t;

endpackage

// ===== src/sem_chan_if.sv =====
// sem_chan_if: valid/ready channel interfaces for requests and results.
// Depends on sem_pkg.
`timescale 1ns / 1ps

interface sem_in_if;
  import sem_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [NOW_W-1:0]   now_time;
  logic [ID_W-1:0]    packet_id;
  logic [SIZE_W-1:0]  packet_size;
  logic [ECN_W-1:0]   ecn_in;
  logic               is_ipv4;

  modport source (output valid, opcode, now_time, packet_id, packet_size, ecn_in,
                  is_ipv4, input ready);
  modport sink   (input valid, opcode, now_time, packet_id, packet_size, ecn_in,
                  is_ipv4, output ready);
endinterface

interface sem_out_if;
  import sem_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    out_packet_id;
  logic [SIZE_W-1:0]  out_size;
  logic [ECN_W-1:0]   out_ecn;
  logic               out_marked;
  logic               out_ipv4;
  logic [QPKT_W-1:0]  queued_packets;
  logic [QBYTE_W-1:0] queued_bytes;

  modport source (output valid, status, out_packet_id, out_size, out_ecn, out_marked,
                  out_ipv4, queued_packets, queued_bytes, input ready);
  modport sink   (input valid, status, out_packet_id, out_size, out_ecn, out_marked,
                  out_ipv4, queued_packets, queued_bytes, output ready);
endinterface

// ===== src/sojourn_ecn_marking_fifo.sv =====
// sojourn_ecn_marking_fifo: top level, ties the request sequencer to the
// queue datapath. Depends on sem_pkg, sem_chan_if, sem_ctrl and sem_dp.
`timescale 1ns / 1ps

// Descriptor FIFO with time-based ECN marking. Each request on in_if
// (enqueue, dequeue or peek) gives exactly one result on out_if. In the
// accept cycle the head entry is read from the entry memory into its
// registered read port; the request then executes (limit check, sojourn
// compare, pointer and count update, memory write for an enqueue) and loads
// the result register. Requests do not overlap; a stalled result register
// holds the execute cycle until out_if.ready frees it, while a waiting
// result does not stop the next request from being accepted. Enqueues are
// tail-dropped when the packet or byte limit (per limit_mode) would be
// exceeded or QUEUE_DEPTH entries are held. Sojourn is now_time minus the
// arrival stamp, modulo 2^TIME_BITS; a dequeued IPv4 ECT(1) packet whose
// sojourn exceeds sojourn_threshold leaves as CE with out_marked set. The
// entry memory needs no clearing after reset: only occupied entries are
// ever used. Config must be written through cfg_we/cfg_index/cfg_data
// while no request is in flight; the block does not enforce this.
module sojourn_ecn_marking_fifo #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int TIME_BITS   = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sem_in_if.sink                         in_if,
  sem_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sem_pkg::*;

  sem_cmd_t  cmd;
  sem_stat_t stat;

  // sequencer: accept, then execute once the result register is free
  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue state, entry memory, marking and result register
  sem_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (in_if.opcode),
    .now_time       (in_if.now_time),
    .packet_id      (in_if.packet_id),
    .packet_size    (in_if.packet_size),
    .ecn_in         (in_if.ecn_in),
    .is_ipv4        (in_if.is_ipv4),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .status         (out_if.status),
    .out_packet_id  (out_if.out_packet_id),
    .out_size       (out_if.out_size),
    .out_ecn        (out_if.out_ecn),
    .out_marked     (out_if.out_marked),
    .out_ipv4       (out_if.out_ipv4),
    .queued_packets (out_if.queued_packets),
    .queued_bytes   (out_if.queued_bytes)
  );

  // one request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while previous one executes");

  // execute only when the result register can take the result
  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_if.valid || out_if.ready))
    else $error("result register overwritten");

  // a new result appears only right after an execute cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.exec))
    else $error("result without execute");

  // a dequeue never marks anything but a packet that leaves as CE
  a_mark_ce: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.out_marked) |->
      (out_if.out_ecn == ECN_CE && out_if.out_ipv4 && out_if.status == ST_DEQUEUED))
    else $error("bad marking result");

endmodule

// ===== src/sem_ctrl.sv =====
// sem_ctrl: two-state request sequencer (accept, execute).
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sem_pkg::sem_stat_t  stat,
  output sem_pkg::sem_cmd_t   cmd
);
  import sem_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ready_r && in_valid) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_EXEC: begin
          // hold until the result register can take the result
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready    = in_ready_r;
  assign cmd.capture = in_ready_r & in_valid;
  assign cmd.exec    = (state_r == S_EXEC) & stat.out_free;

endmodule

// ===== src/sem_dp.sv =====
// sem_dp: config registers, descriptor/stamp memory, pointers, counters,
// limit check, sojourn compare and result register. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_dp #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int TIME_BITS   = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sem_pkg::sem_cmd_t                cmd,
  output sem_pkg::sem_stat_t               stat,
  // config
  input  logic                             cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request payload
  input  logic [sem_pkg::OP_W-1:0]         opcode,
  input  logic [sem_pkg::NOW_W-1:0]        now_time,
  input  logic [sem_pkg::ID_W-1:0]         packet_id,
  input  logic [sem_pkg::SIZE_W-1:0]       packet_size,
  input  logic [sem_pkg::ECN_W-1:0]        ecn_in,
  input  logic                             is_ipv4,
  // result
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sem_pkg::STAT_W-1:0]       status,
  output logic [sem_pkg::ID_W-1:0]         out_packet_id,
  output logic [sem_pkg::SIZE_W-1:0]       out_size,
  output logic [sem_pkg::ECN_W-1:0]        out_ecn,
  output logic                             out_marked,
  output logic                             out_ipv4,
  output logic [sem_pkg::QPKT_W-1:0]       queued_packets,
  output logic [sem_pkg::QBYTE_W-1:0]      queued_bytes
);
  import sem_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int PC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int BC_W    = $clog2(QUEUE_DEPTH) + SIZE_W;
  localparam int STAMP_W = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int CMP_W   = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
  localparam int PL_W    = ((PC_W > MAXP_W) ? PC_W : MAXP_W) + 1;
  localparam int BL_W    = ((BC_W > MAXB_W) ? BC_W : MAXB_W) + 1;
  localparam int MEM_W   = STAMP_W + DESC_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PC_W-1:0]  PC_FULL  = PC_W'(QUEUE_DEPTH);

  // config registers
  logic              limit_mode_r;
  logic [MAXP_W-1:0] max_packets_r;
  logic [MAXB_W-1:0] max_bytes_r;
  logic [THR_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r  <= 1'b0;
      max_packets_r <= MAXP_RST;
      max_bytes_r   <= MAXB_RST;
      thr_r         <= THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMIT_MODE:  limit_mode_r  <= cfg_data[0];
        CFG_MAX_PACKETS: max_packets_r <= cfg_data[MAXP_W-1:0];
        CFG_MAX_BYTES:   max_bytes_r   <= cfg_data[MAXB_W-1:0];
        CFG_SOJOURN_THR: thr_r         <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [OP_W-1:0]   op_r;
  logic [NOW_W-1:0]  now_r;
  logic [ID_W-1:0]   id_r;
  logic [SIZE_W-1:0] size_r;
  logic [ECN_W-1:0]  ecn_r;
  logic              v4_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode;
      now_r  <= now_time;
      id_r   <= packet_id;
      size_r <= packet_size;
      ecn_r  <= ecn_in;
      v4_r   <= is_ipv4;
    end
  end

  // queue state
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PC_W-1:0]  pcnt_r, pcnt_nxt;
  logic [BC_W-1:0]  bcnt_r, bcnt_nxt;

  // entry memory: {stamp, ipv4, ecn, size, id}
  logic [MEM_W-1:0] desc_mem [QUEUE_DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic             wr_en;
  logic [MEM_W-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      desc_mem[tail_r] <= wr_word;
    end
    if (cmd.capture) begin
      rd_data_r <= desc_mem[head_r];
    end
  end

  // head entry fields
  logic [ID_W-1:0]      rd_id;
  logic [SIZE_W-1:0]    rd_size;
  logic [ECN_W-1:0]     rd_ecn;
  logic                 rd_v4;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [TIME_BITS-1:0] sojourn;
  logic [CMP_W-1:0]     soj_x, thr_x;
  logic                 mark;

  assign rd_id    = rd_data_r[ID_W-1:0];
  assign rd_size  = rd_data_r[ID_W +: SIZE_W];
  assign rd_ecn   = rd_data_r[ID_W+SIZE_W +: ECN_W];
  assign rd_v4    = rd_data_r[DESC_W-1];
  assign rd_stamp = rd_data_r[MEM_W-1:DESC_W];
  assign sojourn  = TIME_BITS'(now_r) - TIME_BITS'(rd_stamp);
  assign soj_x    = CMP_W'(sojourn);
  assign thr_x    = CMP_W'(thr_r);
  assign mark     = (soj_x > thr_x) && rd_v4 && (rd_ecn == ECN_ECT_ONE);

  // tail-drop check
  logic [PL_W-1:0] pkt_plus;
  logic [BL_W-1:0] byte_plus;
  logic            drop;

  assign pkt_plus  = PL_W'(pcnt_r) + PL_W'(1);
  assign byte_plus = BL_W'(bcnt_r) + BL_W'(size_r);

  always_comb begin
    if (limit_mode_r) begin
      drop = pkt_plus > PL_W'(max_packets_r);
    end else begin
      drop = byte_plus > BL_W'(max_bytes_r);
    end
    if (pcnt_r >= PC_FULL) begin
      drop = 1'b1;
    end
  end

  // step result
  sem_status_t       st_nxt;
  logic [ID_W-1:0]   oid_nxt;
  logic [SIZE_W-1:0] osize_nxt;
  logic [ECN_W-1:0]  oecn_nxt;
  logic              omark_nxt;
  logic              ov4_nxt;

  assign wr_word = {STAMP_W'(now_r), v4_r, ecn_r, size_r, id_r};

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    pcnt_nxt  = pcnt_r;
    bcnt_nxt  = bcnt_r;
    wr_en     = 1'b0;
    st_nxt    = ST_EMPTY;
    oid_nxt   = '0;
    osize_nxt = '0;
    oecn_nxt  = '0;
    omark_nxt = 1'b0;
    ov4_nxt   = 1'b0;
    unique case (op_r)
      OP_ENQ: begin
        if (drop) begin
          st_nxt = ST_DROPPED;
        end else begin
          st_nxt   = ST_ACCEPTED;
          wr_en    = cmd.exec;
          tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
          pcnt_nxt = pcnt_r + PC_W'(1);
          bcnt_nxt = bcnt_r + BC_W'(size_r);
        end
      end
      OP_DEQ: begin
        if (pcnt_r != '0) begin
          st_nxt    = ST_DEQUEUED;
          oid_nxt   = rd_id;
          osize_nxt = rd_size;
          oecn_nxt  = mark ? ECN_CE : rd_ecn;
          omark_nxt = mark;
          ov4_nxt   = rd_v4;
          head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
          pcnt_nxt  = pcnt_r - PC_W'(1);
          bcnt_nxt  = bcnt_r - BC_W'(rd_size);
        end
      end
      default: begin
        // peek, also taken by the unused opcode
        if (pcnt_r != '0) begin
          st_nxt    = ST_PEEKED;
          oid_nxt   = rd_id;
          osize_nxt = rd_size;
          oecn_nxt  = rd_ecn;
          ov4_nxt   = rd_v4;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      pcnt_r <= '0;
      bcnt_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      pcnt_r <= pcnt_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  // result register
  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r;
  logic [ID_W-1:0]    oid_r;
  logic [SIZE_W-1:0]  osize_r;
  logic [ECN_W-1:0]   oecn_r;
  logic               omark_r;
  logic               ov4_r;
  logic [QPKT_W-1:0]  qpkt_r;
  logic [QBYTE_W-1:0] qbyte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= st_nxt;
      oid_r    <= oid_nxt;
      osize_r  <= osize_nxt;
      oecn_r   <= oecn_nxt;
      omark_r  <= omark_nxt;
      ov4_r    <= ov4_nxt;
      qpkt_r   <= QPKT_W'(pcnt_nxt);
      qbyte_r  <= QBYTE_W'(bcnt_nxt);
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign status          = status_r;
  assign out_packet_id   = oid_r;
  assign out_size        = osize_r;
  assign out_ecn         = oecn_r;
  assign out_marked      = omark_r;
  assign out_ipv4        = ov4_r;
  assign queued_packets  = qpkt_r;
  assign queued_bytes    = qbyte_r;

endmodule
